// ===== hw/rtl/nfcr_pkg.sv =====
// Shared types and constants for the NFC response frame receiver.
`default_nettype none

package nfcr_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_DATA  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_PROGRESS = 3'd0,
    ST_DONE     = 3'd1,
    ST_BUSY     = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_PREAMBLE = 3'd4,
    ST_APP_ERR  = 3'd5,
    ST_EXTENDED = 3'd6,
    ST_LEN_CSUM = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_POLL    = 2'd1,
    PH_HEADER  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  // configuration register indexes
  localparam logic CFG_TIMEOUT_LIMIT = 1'b0;
  localparam logic CFG_SHORT_REPLY   = 1'b1;

  localparam logic [7:0] TIMEOUT_RESET   = 8'd100;
  localparam logic [7:0] READY_BYTE      = 8'h01;
  localparam logic [7:0] PREAMBLE_LOW    = 8'h00;
  localparam logic [7:0] PREAMBLE_START  = 8'hFF;
  localparam logic [7:0] LEN_APP_ERR     = 8'h01;
  localparam logic [7:0] LEN_EXTENDED    = 8'hFF;
  localparam logic [7:0] LCS_SPECIAL     = 8'hFF;
  localparam logic [8:0] LEN_LCS_SUM     = 9'd256;
  localparam logic [8:0] SHORT_FRAME_LEN = 9'd6;
  localparam logic [8:0] FRAME_OVERHEAD  = 9'd7;

  // header byte positions
  localparam logic [8:0] POS_PRE0 = 9'd0;
  localparam logic [8:0] POS_PRE1 = 9'd1;
  localparam logic [8:0] POS_PRE2 = 9'd2;
  localparam logic [8:0] POS_LEN  = 9'd3;
  localparam logic [8:0] POS_LCS  = 9'd4;

  typedef struct packed {
    logic [2:0] status;
    logic       byte_valid;
    logic [8:0] byte_position;
    logic [7:0] byte_value;
    logic [8:0] frame_length;
    logic [7:0] app_error;
    logic       awaiting_data;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nfcr_core.sv =====
// Frame receive state, config registers and per-word result logic.
`default_nettype none

module nfcr_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            accept,
  input  wire logic [1:0]      command,
  input  wire logic [7:0]      rx_byte,
  input  wire logic            cfg_we,
  input  wire logic            cfg_index,
  input  wire logic [7:0]      cfg_wdata,
  output nfcr_pkg::result_t    res
);
  import nfcr_pkg::*;

  logic [7:0] timeout_limit_r;
  logic       short_reply_r;

  phase_t     phase_r,       phase_nxt;
  logic [8:0] poll_count_r,  poll_count_nxt;
  logic [8:0] position_r,    position_nxt;
  logic [7:0] length_byte_r, length_byte_nxt;
  logic [8:0] bytes_left_r,  bytes_left_nxt;
  logic [7:0] err_code_r,    err_code_nxt;
  logic       pre_bad_r,     pre_bad_nxt;

  logic [8:0] pos_inc;
  logic [8:0] left_dec;
  logic [7:0] lcs;
  logic [8:0] len_lcs;

  assign pos_inc  = position_r + 9'd1;
  assign left_dec = bytes_left_r - 9'd1;
  assign lcs      = bytes_left_r[7:0];
  assign len_lcs  = {1'b0, length_byte_r} + {1'b0, lcs};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_limit_r <= TIMEOUT_RESET;
      short_reply_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT_LIMIT: timeout_limit_r <= cfg_wdata;
        CFG_SHORT_REPLY:   short_reply_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      poll_count_r  <= '0;
      position_r    <= '0;
      length_byte_r <= '0;
      bytes_left_r  <= '0;
      err_code_r    <= '0;
      pre_bad_r     <= 1'b0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      poll_count_r  <= poll_count_nxt;
      position_r    <= position_nxt;
      length_byte_r <= length_byte_nxt;
      bytes_left_r  <= bytes_left_nxt;
      err_code_r    <= err_code_nxt;
      pre_bad_r     <= pre_bad_nxt;
    end
  end

  always_comb begin
    status_t st;
    logic    pre_bad_now;
    st              = ST_PROGRESS;
    pre_bad_now     = pre_bad_r;
    phase_nxt       = phase_r;
    poll_count_nxt  = poll_count_r;
    position_nxt    = position_r;
    length_byte_nxt = length_byte_r;
    bytes_left_nxt  = bytes_left_r;
    err_code_nxt    = err_code_r;
    pre_bad_nxt     = pre_bad_r;
    res             = '0;

    case (cmd_t'(command))
      CMD_START: begin
        if (phase_r != PH_IDLE) begin
          st = ST_BUSY;
        end else begin
          phase_nxt       = PH_POLL;
          poll_count_nxt  = '0;
          position_nxt    = '0;
          length_byte_nxt = '0;
          bytes_left_nxt  = '0;
          err_code_nxt    = '0;
          pre_bad_nxt     = 1'b0;
        end
      end
      CMD_POLL: begin
        if (phase_r == PH_POLL) begin
          if (rx_byte == READY_BYTE) begin
            phase_nxt    = PH_HEADER;
            position_nxt = '0;
            pre_bad_nxt  = 1'b0;
          end else if (poll_count_r > {1'b0, timeout_limit_r}) begin
            st        = ST_TIMEOUT;
            phase_nxt = PH_IDLE;
          end else begin
            poll_count_nxt = poll_count_r + 9'd1;
          end
        end
      end
      CMD_DATA: begin
        if (phase_r == PH_HEADER || phase_r == PH_PAYLOAD) begin
          res.byte_valid    = 1'b1;
          res.byte_position = position_r;
          res.byte_value    = rx_byte;
          position_nxt      = pos_inc;
          if (phase_r == PH_HEADER) begin
            if (position_r == POS_PRE0 || position_r == POS_PRE1) begin
              if (rx_byte != PREAMBLE_LOW) pre_bad_nxt = 1'b1;
            end else if (position_r == POS_PRE2) begin
              pre_bad_now = pre_bad_r | (rx_byte != PREAMBLE_START);
              pre_bad_nxt = pre_bad_now;
              if (pre_bad_now) begin
                st        = ST_PREAMBLE;
                phase_nxt = PH_IDLE;
              end
            end else if (position_r == POS_LEN) begin
              length_byte_nxt = rx_byte;
            end else if (position_r == POS_LCS) begin
              bytes_left_nxt = {1'b0, rx_byte};
            end else begin
              // TFI: classify the frame
              if (length_byte_r == LEN_APP_ERR && lcs == LCS_SPECIAL) begin
                err_code_nxt = rx_byte;
                st           = ST_APP_ERR;
                phase_nxt    = PH_IDLE;
              end else if (length_byte_r == LEN_EXTENDED && lcs == LCS_SPECIAL) begin
                st        = ST_EXTENDED;
                phase_nxt = PH_IDLE;
              end else if (short_reply_r) begin
                st               = ST_DONE;
                res.frame_length = SHORT_FRAME_LEN;
                phase_nxt        = PH_IDLE;
              end else if (len_lcs != LEN_LCS_SUM) begin
                st        = ST_LEN_CSUM;
                phase_nxt = PH_IDLE;
              end else begin
                bytes_left_nxt = {1'b0, length_byte_r} + 9'd1;
                phase_nxt      = PH_PAYLOAD;
              end
            end
          end else begin
            bytes_left_nxt = left_dec;
            if (left_dec == 9'd0) begin
              st               = ST_DONE;
              res.frame_length = {1'b0, length_byte_r} + FRAME_OVERHEAD;
              phase_nxt        = PH_IDLE;
            end
          end
        end
      end
      default: ;
    endcase

    res.status        = st;
    res.app_error     = err_code_nxt;
    res.awaiting_data = (phase_nxt == PH_HEADER || phase_nxt == PH_PAYLOAD);
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nfcr_out_reg.sv =====
// Result register between the receive logic and the output channel.
`default_nettype none

module nfcr_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output      logic            in_ready,
  input  wire nfcr_pkg::result_t res_in,
  output      logic            out_valid,
  input  wire logic            out_ready,
  output nfcr_pkg::result_t    res_out
);
  import nfcr_pkg::*;

  logic    valid_r;
  result_t res_r;

  // the register frees up in the same cycle its word is taken
  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign res_out   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nfc_response_frame_receiver.sv =====
// Top level of the NFC response frame receiver.
//
// Input channel (in_valid/in_ready): one word per command: start, status
// poll byte or frame data byte (in_command, in_rx_byte).
// Output channel (out_valid/out_ready): exactly one result word per input
// word, in order: status, echoed frame byte with its position, frame length,
// held application error code and whether frame bytes are expected next.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 timeout limit, index 1
// short reply mode; the user must write it only while the block is idle,
// which the block does not enforce. A result appears in the cycle after its
// word is accepted. Throughput: one word per cycle; the receive state is
// updated in a single pass of compare logic between the input handshake
// and the result register. A stalled output holds its result; in_ready stays
// high while the result register is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): block idle, counters and held error code
// cleared, timeout limit 100, short reply mode off, no result pending.
`default_nettype none

module nfc_response_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_rx_byte,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      logic [2:0] out_status,
  output      logic       out_byte_valid,
  output      logic [8:0] out_byte_position,
  output      logic [7:0] out_byte_value,
  output      logic [8:0] out_frame_length,
  output      logic [7:0] out_app_error,
  output      logic       out_awaiting_data,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import nfcr_pkg::*;

  result_t res_nxt;
  result_t res_q;

  nfcr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_valid && in_ready),
    .command   (in_command),
    .rx_byte   (in_rx_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res_nxt)
  );

  nfcr_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .res_in    (res_nxt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_q)
  );

  assign out_status        = res_q.status;
  assign out_byte_valid    = res_q.byte_valid;
  assign out_byte_position = res_q.byte_position;
  assign out_byte_value    = res_q.byte_value;
  assign out_frame_length  = res_q.frame_length;
  assign out_app_error     = res_q.app_error;
  assign out_awaiting_data = res_q.awaiting_data;

endmodule

`default_nettype wire

// ===== hw/rtl/nfcr_checker.sv =====
// Port-level assertions for the NFC response frame receiver, with bind.
`default_nettype none

module nfcr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic       out_byte_valid,
  input wire logic [8:0] out_byte_position,
  input wire logic [7:0] out_byte_value,
  input wire logic [8:0] out_frame_length,
  input wire logic       out_awaiting_data
);
  import nfcr_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_byte_position) && $stable(out_byte_value))
    else $error("result word changed while stalled");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_byte_position == 9'd0 &&
      out_byte_value == 8'd0)
    else $error("byte fields set without a delivered byte");

  a_len_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_frame_length == 9'd0)
    else $error("frame length reported without done");

  a_end_not_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_PROGRESS && out_status != ST_BUSY
      |-> !out_awaiting_data)
    else $error("still expecting data after frame end");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind nfc_response_frame_receiver nfcr_checker u_nfcr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_byte_valid    (out_byte_valid),
  .out_byte_position (out_byte_position),
  .out_byte_value    (out_byte_value),
  .out_frame_length  (out_frame_length),
  .out_awaiting_data (out_awaiting_data)
);

`default_nettype wire
